// ----- src/eabv_pkg.sv -----
// shared types, coefficients and fixed-point helpers for the orientation basis block
package eabv_pkg;

    localparam int FRAC = 30;

    typedef logic signed [32:0] trig_t;
    typedef logic signed [34:0] sum_t;
    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        comp_t up_z;
        comp_t up_y;
        comp_t up_x;
        comp_t right_z;
        comp_t right_y;
        comp_t right_x;
        comp_t forward_z;
        comp_t forward_y;
        comp_t forward_x;
    } basis_t;

    localparam logic [31:0] K13 = 32'd61;
    localparam int HORNER_STEPS = 6;

    // horner coefficients from the innermost term outwards
    function automatic logic [31:0] coef(input int idx);
        logic [31:0] k;
        case (idx)
            0:       k = 32'd3864;
            1:       k = 32'd172272;
            2:       k = 32'd5026995;
            3:       k = 32'd85569306;
            4:       k = 32'd693598668;
            default: k = 32'd1686629713;
        endcase
        return k;
    endfunction

    function automatic logic [30:0] square_q30(input logic [30:0] t);
        logic [61:0] p;
        p = 62'(t) * 62'(t);
        return p[60:30];
    endfunction

    function automatic logic [31:0] horner_step(input logic [31:0] k, input logic [30:0] t2,
                                                input logic [31:0] h);
        logic [62:0] p;
        logic [32:0] d;
        p = 63'(t2) * 63'(h);
        d = {1'b0, k} - p[62:30];
        return d[31:0];
    endfunction

    function automatic trig_t final_q30(input logic [30:0] t, input logic [31:0] h);
        logic [62:0] p;
        p = 63'(t) * 63'(h);
        return trig_t'(p[62:30]);
    endfunction

    // product rounded back to q2.30, halves toward plus infinity
    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        p = p + (66'sd1 <<< (FRAC - 1));
        p = p >>> FRAC;
        return p[32:0];
    endfunction

    function automatic comp_t to_out(input sum_t v, input int ofb);
        logic signed [35:0] r;
        logic signed [35:0] lim;
        r   = (36'(v) + (36'sd1 <<< (FRAC - ofb - 1))) >>> (FRAC - ofb);
        lim = 36'sd1 <<< ofb;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

endpackage

// ----- src/eabv_sincos.sv -----
// pipelined sine and cosine of one binary angle, horner polynomial per stage
module eabv_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [15:0]     angle,
    output logic            out_valid,
    output eabv_pkg::trig_t sin_val,
    output eabv_pkg::trig_t cos_val
);
    import eabv_pkg::*;

    localparam int LAST = HORNER_STEPS + 1;

    logic [ANGLE_BITS-1:0] a;
    logic [30:0]           t_in;

    logic [LAST+1:0] vld_reg;
    logic [1:0]      quad_reg [0:LAST];
    logic [30:0]     tu_reg   [0:LAST];
    logic [30:0]     td_reg   [0:LAST];
    logic [30:0]     t2u_reg  [1:LAST];
    logic [30:0]     t2d_reg  [1:LAST];
    logic [31:0]     hu_reg   [1:LAST];
    logic [31:0]     hd_reg   [1:LAST];
    trig_t           qu, qd;
    trig_t           sin_reg, cos_reg;

    assign a    = ANGLE_BITS'(angle);
    assign t_in = 31'(a[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST:0], in_valid};
    end

    // angle split and square of t
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= a[ANGLE_BITS-1 -: 2];
            tu_reg[0]   <= t_in;
            td_reg[0]   <= (31'd1 << FRAC) - t_in;
            quad_reg[1] <= quad_reg[0];
            tu_reg[1]   <= tu_reg[0];
            td_reg[1]   <= td_reg[0];
            t2u_reg[1]  <= square_q30(tu_reg[0]);
            t2d_reg[1]  <= square_q30(td_reg[0]);
            hu_reg[1]   <= K13;
            hd_reg[1]   <= K13;
        end
    end

    for (genvar k = 2; k <= LAST; k++)
    begin : g_horner
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[k] <= quad_reg[k-1];
                tu_reg[k]   <= tu_reg[k-1];
                td_reg[k]   <= td_reg[k-1];
                t2u_reg[k]  <= t2u_reg[k-1];
                t2d_reg[k]  <= t2d_reg[k-1];
                hu_reg[k]   <= horner_step(coef(k - 2), t2u_reg[k-1], hu_reg[k-1]);
                hd_reg[k]   <= horner_step(coef(k - 2), t2d_reg[k-1], hd_reg[k-1]);
            end
        end
    end

    assign qu = final_q30(tu_reg[LAST], hu_reg[LAST]);
    assign qd = final_q30(td_reg[LAST], hd_reg[LAST]);

    // quadrant symmetry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad_reg[LAST])
                2'd0:
                begin
                    sin_reg <= qu;
                    cos_reg <= qd;
                end
                2'd1:
                begin
                    sin_reg <= qd;
                    cos_reg <= -qu;
                end
                2'd2:
                begin
                    sin_reg <= -qu;
                    cos_reg <= -qd;
                end
                default:
                begin
                    sin_reg <= -qd;
                    cos_reg <= qu;
                end
            endcase
        end
    end

    assign out_valid = vld_reg[LAST+1];
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;

endmodule

// ----- src/eabv_basis.sv -----
// products and sums that form the three basis vectors, three register stages
module eabv_basis #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  eabv_pkg::trig_t  sp,
    input  eabv_pkg::trig_t  cp,
    input  eabv_pkg::trig_t  sy,
    input  eabv_pkg::trig_t  cy,
    input  eabv_pkg::trig_t  sr,
    input  eabv_pkg::trig_t  cr,
    output logic             out_valid,
    output eabv_pkg::basis_t vec
);
    import eabv_pkg::*;

    logic [2:0] vld_reg;
    trig_t srp_reg, crp_reg, sp1_reg, cp1_reg, sy1_reg, cy1_reg, sr1_reg, cr1_reg;
    trig_t p_cpcy_reg, p_cpsy_reg, sp2_reg, p_srpcy_reg, p_crsy_reg, p_srpsy_reg;
    trig_t p_crcy_reg, p_srcp_reg, p_crpcy_reg, p_srsy_reg, p_crpsy_reg, p_srcy_reg;
    trig_t p_crcp_reg;
    basis_t vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // roll times pitch sine
            srp_reg <= mul_q30(sr, sp);
            crp_reg <= mul_q30(cr, sp);
            sp1_reg <= sp;
            cp1_reg <= cp;
            sy1_reg <= sy;
            cy1_reg <= cy;
            sr1_reg <= sr;
            cr1_reg <= cr;
            // products needed for the basis components
            p_cpcy_reg  <= mul_q30(cp1_reg, cy1_reg);
            p_cpsy_reg  <= mul_q30(cp1_reg, sy1_reg);
            sp2_reg     <= sp1_reg;
            p_srpcy_reg <= mul_q30(srp_reg, cy1_reg);
            p_crsy_reg  <= mul_q30(cr1_reg, sy1_reg);
            p_srpsy_reg <= mul_q30(srp_reg, sy1_reg);
            p_crcy_reg  <= mul_q30(cr1_reg, cy1_reg);
            p_srcp_reg  <= mul_q30(sr1_reg, cp1_reg);
            p_crpcy_reg <= mul_q30(crp_reg, cy1_reg);
            p_srsy_reg  <= mul_q30(sr1_reg, sy1_reg);
            p_crpsy_reg <= mul_q30(crp_reg, sy1_reg);
            p_srcy_reg  <= mul_q30(sr1_reg, cy1_reg);
            p_crcp_reg  <= mul_q30(cr1_reg, cp1_reg);
            // sums, rounding and saturation
            vec_reg.forward_x <= to_out(sum_t'(p_cpcy_reg), OUT_FRAC_BITS);
            vec_reg.forward_y <= to_out(sum_t'(p_cpsy_reg), OUT_FRAC_BITS);
            vec_reg.forward_z <= to_out(-sum_t'(sp2_reg), OUT_FRAC_BITS);
            vec_reg.right_x   <= to_out(sum_t'(p_crsy_reg) - sum_t'(p_srpcy_reg),
                                        OUT_FRAC_BITS);
            vec_reg.right_y   <= to_out(-sum_t'(p_srpsy_reg) - sum_t'(p_crcy_reg),
                                        OUT_FRAC_BITS);
            vec_reg.right_z   <= to_out(-sum_t'(p_srcp_reg), OUT_FRAC_BITS);
            vec_reg.up_x      <= to_out(sum_t'(p_crpcy_reg) + sum_t'(p_srsy_reg),
                                        OUT_FRAC_BITS);
            vec_reg.up_y      <= to_out(sum_t'(p_crpsy_reg) - sum_t'(p_srcy_reg),
                                        OUT_FRAC_BITS);
            vec_reg.up_z      <= to_out(sum_t'(p_crcp_reg), OUT_FRAC_BITS);
        end
    end

    assign out_valid = vld_reg[2];
    assign vec       = vec_reg;

endmodule

// ----- src/euler_angles_to_basis_vectors_top.sv -----
// top level: pitch, yaw and roll binary angles to forward, right and up vectors
// pipeline: 12 register stages from the accepting edge to m_tvalid
//   (9 in the sine and cosine pipelines, 3 in the product and sum pipeline)
// throughput: one request per cycle; the whole pipeline advances together and holds
//   only while a finished result waits at the output register
// reset: rst_n asynchronous, active low, clears every stage valid bit; data unreset
module euler_angles_to_basis_vectors_top #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // pitch_angle[15:0], yaw_angle[31:16], roll_angle[47:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    // forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y, up_z,
    // 16 bits each from the lowest bit up
    output logic [143:0] m_tdata
);
    import eabv_pkg::*;

    logic   en;
    logic   vp, vy, vr;
    trig_t  sp, cp, sy, cy, sr, cr;
    basis_t vec;

    // single pipeline enable: move when the output register is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[15:0]), .out_valid(vp), .sin_val(sp), .cos_val(cp)
    );

    eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[31:16]), .out_valid(vy), .sin_val(sy), .cos_val(cy)
    );

    eabv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .angle(s_tdata[47:32]), .out_valid(vr), .sin_val(sr), .cos_val(cr)
    );

    // the three angle pipelines run in lock step, so any one valid serves
    eabv_basis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_basis (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vp && vy && vr),
        .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
        .out_valid(m_tvalid), .vec(vec)
    );

    assign m_tdata = {vec.up_z, vec.up_y, vec.up_x,
                      vec.right_z, vec.right_y, vec.right_x,
                      vec.forward_z, vec.forward_y, vec.forward_x};

`ifndef SYNTHESIS
    // a stall only comes from a full output register that is not being taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // the angle pipelines must agree on which stages hold requests
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (vp == vy) && (vy == vr))
        else $error("angle pipelines out of step");

    // pitch sine component stays within the saturation limit
    a_fwd_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((OUT_FRAC_BITS > 14)
                      || (($signed(m_tdata[47:32]) <= (32'sd1 <<< OUT_FRAC_BITS))
                          && ($signed(m_tdata[47:32]) >= -(32'sd1 <<< OUT_FRAC_BITS)))))
        else $error("forward_z beyond unit magnitude");

    // up_z stays within the saturation limit
    a_up_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((OUT_FRAC_BITS > 14)
                      || (($signed(m_tdata[143:128]) <= (32'sd1 <<< OUT_FRAC_BITS))
                          && ($signed(m_tdata[143:128]) >= -(32'sd1 <<< OUT_FRAC_BITS)))))
        else $error("up_z beyond unit magnitude");
`endif

endmodule
